@@ hdl/pnci_pkg.sv @@
// Shared types, constants and the divider step for the neighbor cell index block.
`default_nettype none
package pnci_pkg;

    localparam int POS_W  = 16;
    localparam int SIZE_W = 8;
    localparam int CNT_W  = 9;
    localparam int REM_W  = 9;
    localparam int IDX_W  = 16;
    localparam int SLOT_W = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int MAX_CELLS_DEF = 256;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RST  = 8'd10;
    localparam logic [CNT_W-1:0]  CELL_COUNT_RST = 9'd100;

    localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd8;

    typedef enum logic [1:0] {
        REG_CELL_WIDTH   = 2'd0,
        REG_CELL_HEIGHT  = 2'd1,
        REG_CELLS_ACROSS = 2'd2,
        REG_CELLS_DOWN   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [POS_W-1:0] dvd;
    } div_st_t;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic div_st_t div_step(input logic [REM_W-1:0] rem,
                                         input logic [POS_W-1:0] dvd,
                                         input logic [REM_W-1:0] dvs);
        logic [REM_W:0] t;
        div_st_t        o;
        t = {rem, dvd[POS_W-1]};
        if (t >= {1'b0, dvs}) begin
            t     = t - {1'b0, dvs};
            o.dvd = {dvd[POS_W-2:0], 1'b1};
        end else begin
            o.dvd = {dvd[POS_W-2:0], 1'b0};
        end
        o.rem = t[REM_W-1:0];
        return o;
    endfunction

endpackage
`default_nettype wire

@@ hdl/periodic_neighbor_cell_indices.sv @@
// Neighbor cell index generator for a periodic 2D cell grid.
//
//  channel   direction  ports                               handshake
//  s_        in         s_pos_x, s_pos_y                    s_valid / s_ready
//  m_        out        m_cell_index, m_neighbor_slot,      m_valid / m_ready
//                       m_last
//  apb       in/out     psel penable pwrite paddr pwdata    pready (always high)
//
// Each position yields nine results, one per cycle while m_ready is high; the emitter
// takes a new position in the cycle that its last result is taken.
// From request to first result a position passes two 16-step pipelined
// dividers (position / cell size, then column and row modulo cell count) and the emitter.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole divider pipeline once its tail holds a position; nothing is dropped.
`default_nettype none
module periodic_neighbor_cell_indices
    import pnci_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [POS_W-1:0]  s_pos_x,
    input  wire logic signed [POS_W-1:0]  s_pos_y,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [IDX_W-1:0]              m_cell_index,
    output logic [SLOT_W-1:0]             m_neighbor_slot,
    output logic                          m_last,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    localparam int NS = POS_W;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CELLS_PER_AXIS);

    logic [SIZE_W-1:0] cell_width_reg, cell_height_reg;
    logic [CNT_W-1:0]  cells_across_reg, cells_down_reg;
    logic [SIZE_W-1:0] cw_eff, ch_eff;
    logic [CNT_W-1:0]  nx_eff, ny_eff;
    reg_idx_t          reg_sel;
    logic              cfg_wr;

    // divider 1: position / cell size; divider 2: column and row modulo cell count
    logic              v1_reg [0:NS];
    logic              v2_reg [0:NS];
    logic [POS_W-1:0]  xa1_reg [0:NS], ya1_reg [0:NS];
    logic [REM_W-1:0]  xr1_reg [0:NS], yr1_reg [0:NS];
    logic              xn1_reg [0:NS], yn1_reg [0:NS];
    logic [POS_W-1:0]  xa2_reg [0:NS], ya2_reg [0:NS];
    logic [REM_W-1:0]  xr2_reg [0:NS], yr2_reg [0:NS];
    logic              xn2_reg [0:NS], yn2_reg [0:NS];

    logic              ser_valid_reg;
    logic [1:0]        cx_reg, cy_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  c0_reg, r0_reg;

    logic              m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic [SLOT_W-1:0] m_slot_reg;

    logic              out_load, ser_free, adv;
    logic [POS_W-1:0]  x_dvd, y_dvd;
    logic [CNT_W-1:0]  mx, my, col, row;
    logic [2*CNT_W-1:0] prod;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign cw_eff = (cell_width_reg == '0) ? SIZE_W'(1) : cell_width_reg;
    assign ch_eff = (cell_height_reg == '0) ? SIZE_W'(1) : cell_height_reg;
    assign nx_eff = (cells_across_reg == '0) ? CNT_W'(1) :
                    (cells_across_reg > MAX_N) ? MAX_N : cells_across_reg;
    assign ny_eff = (cells_down_reg == '0) ? CNT_W'(1) :
                    (cells_down_reg > MAX_N) ? MAX_N : cells_down_reg;

    always_comb begin
        unique case (reg_sel)
            REG_CELL_WIDTH:   prdata = DATA_W'(cell_width_reg);
            REG_CELL_HEIGHT:  prdata = DATA_W'(cell_height_reg);
            REG_CELLS_ACROSS: prdata = DATA_W'(cells_across_reg);
            REG_CELLS_DOWN:   prdata = DATA_W'(cells_down_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_width_reg   <= CELL_SIZE_RST;
            cell_height_reg  <= CELL_SIZE_RST;
            cells_across_reg <= CELL_COUNT_RST;
            cells_down_reg   <= CELL_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CELL_WIDTH:   cell_width_reg   <= pwdata[SIZE_W-1:0];
                REG_CELL_HEIGHT:  cell_height_reg  <= pwdata[SIZE_W-1:0];
                REG_CELLS_ACROSS: cells_across_reg <= pwdata[CNT_W-1:0];
                REG_CELLS_DOWN:   cells_down_reg   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: the pipeline shifts as a whole unless its tail is blocked.
    assign out_load = !m_valid_reg || m_ready;
    assign ser_free = !ser_valid_reg || (out_load && slot_reg == SLOT_LAST);
    assign adv      = !v2_reg[NS] || ser_free;
    assign s_ready  = adv;

    // Negative input: floor(x/w) = -ceil(|x|/w), and |x| + w - 1 = ~x + w.
    assign x_dvd = s_pos_x[POS_W-1] ? (~s_pos_x + POS_W'(cw_eff)) : s_pos_x;
    assign y_dvd = s_pos_y[POS_W-1] ? (~s_pos_y + POS_W'(ch_eff)) : s_pos_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NS; i++) begin
                v1_reg[i] <= 1'b0;
                v2_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg[0] <= s_valid;
            for (int i = 0; i < NS; i++) begin
                v1_reg[i+1] <= v1_reg[i];
                v2_reg[i+1] <= v2_reg[i];
            end
            v2_reg[0] <= v1_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xa1_reg[0] <= x_dvd;
            ya1_reg[0] <= y_dvd;
            xr1_reg[0] <= '0;
            yr1_reg[0] <= '0;
            xn1_reg[0] <= s_pos_x[POS_W-1];
            yn1_reg[0] <= s_pos_y[POS_W-1];
            for (int i = 0; i < NS; i++) begin
                {xr1_reg[i+1], xa1_reg[i+1]} <=
                    div_step(xr1_reg[i], xa1_reg[i], REM_W'(cw_eff));
                {yr1_reg[i+1], ya1_reg[i+1]} <=
                    div_step(yr1_reg[i], ya1_reg[i], REM_W'(ch_eff));
                xn1_reg[i+1] <= xn1_reg[i];
                yn1_reg[i+1] <= yn1_reg[i];
            end
            xa2_reg[0] <= xa1_reg[NS];
            ya2_reg[0] <= ya1_reg[NS];
            xr2_reg[0] <= '0;
            yr2_reg[0] <= '0;
            xn2_reg[0] <= xn1_reg[NS];
            yn2_reg[0] <= yn1_reg[NS];
            for (int i = 0; i < NS; i++) begin
                {xr2_reg[i+1], xa2_reg[i+1]} <= div_step(xr2_reg[i], xa2_reg[i], nx_eff);
                {yr2_reg[i+1], ya2_reg[i+1]} <= div_step(yr2_reg[i], ya2_reg[i], ny_eff);
                xn2_reg[i+1] <= xn2_reg[i];
                yn2_reg[i+1] <= yn2_reg[i];
            end
        end
    end

    // Non-negative modulo of the signed cell coordinate.
    assign mx = (xn2_reg[NS] && xr2_reg[NS] != '0) ? nx_eff - xr2_reg[NS] : xr2_reg[NS];
    assign my = (yn2_reg[NS] && yr2_reg[NS] != '0) ? ny_eff - yr2_reg[NS] : yr2_reg[NS];

    always_comb begin
        case (cx_reg)
            2'd0:    col = (c0_reg == '0) ? nx_eff - CNT_W'(1) : c0_reg - CNT_W'(1);
            2'd2:    col = (c0_reg == nx_eff - CNT_W'(1)) ? '0 : c0_reg + CNT_W'(1);
            default: col = c0_reg;
        endcase
        case (cy_reg)
            2'd0:    row = (r0_reg == '0) ? ny_eff - CNT_W'(1) : r0_reg - CNT_W'(1);
            2'd2:    row = (r0_reg == ny_eff - CNT_W'(1)) ? '0 : r0_reg + CNT_W'(1);
            default: row = r0_reg;
        endcase
        prod = col * ny_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= ser_valid_reg;
            end
            if (adv && v2_reg[NS]) begin
                ser_valid_reg <= 1'b1;
            end else if (ser_free) begin
                ser_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v2_reg[NS]) begin
            c0_reg   <= mx;
            r0_reg   <= my;
            cx_reg   <= 2'd0;
            cy_reg   <= 2'd0;
            slot_reg <= '0;
        end else if (out_load && ser_valid_reg) begin
            slot_reg <= slot_reg + SLOT_W'(1);
            if (cy_reg == 2'd2) begin
                cy_reg <= 2'd0;
                cx_reg <= cx_reg + 2'd1;
            end else begin
                cy_reg <= cy_reg + 2'd1;
            end
        end
        if (out_load && ser_valid_reg) begin
            m_index_reg <= prod[IDX_W-1:0] + IDX_W'(row);
            m_slot_reg  <= slot_reg;
            m_last_reg  <= (slot_reg == SLOT_LAST);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_index    = m_index_reg;
    assign m_neighbor_slot = m_slot_reg;
    assign m_last          = m_last_reg;

`ifndef SYNTH
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> slot_reg <= SLOT_LAST)
        else $error("emitter slot out of range");
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_slot_reg == SLOT_LAST)
        else $error("last flag on wrong slot");
    a_coord_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> c0_reg < nx_eff && r0_reg < ny_eff)
        else $error("cell coordinate outside grid");
    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg[NS] && !adv |=> v2_reg[NS] && $stable(xa2_reg[NS]) && $stable(xr2_reg[NS]))
        else $error("pipeline tail changed while stalled");
`endif

endmodule
`default_nettype wire

@@ bench/periodic_neighbor_cell_indices_tb.sv @@
// Testbench for the periodic neighbor cell index block: directed and random positions.
`timescale 1ns / 100ps
module periodic_neighbor_cell_indices_tb;
    import pnci_pkg::*;

    typedef struct {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } pos_req_t;

    typedef struct {
        logic [IDX_W-1:0]  cell_index;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } cell_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [POS_W-1:0] s_pos_x = '0;
    logic signed [POS_W-1:0] s_pos_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_cell_index;
    logic [SLOT_W-1:0] m_neighbor_slot;
    logic m_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    periodic_neighbor_cell_indices uut (.*);

    always #5 aclk = ~aclk;

    pos_req_t  pending_pos[$];
    cell_res_t expected_cells[$];
    int unsigned cfg_width = 10, cfg_height = 10, cfg_across = 100, cfg_down = 100;
    int errors = 0;
    int results_seen = 0;
    int positions_sent = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 28;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int idle_cycles = 0;

    // Predict the nine neighbor indices of one accepted position.
    task automatic predict_cells(input logic [15:0] px_in, input logic [15:0] py_in);
        longint x, y, cw, ch, nx, ny, bx, by, px, py;
        cell_res_t r;
        int k;
        x = longint'($signed(px_in));
        y = longint'($signed(py_in));
        cw = (cfg_width == 0) ? 1 : cfg_width;
        ch = (cfg_height == 0) ? 1 : cfg_height;
        nx = (cfg_across == 0) ? 1 : (cfg_across > 256 ? 256 : cfg_across);
        ny = (cfg_down == 0) ? 1 : (cfg_down > 256 ? 256 : cfg_down);
        bx = cw * nx;
        by = ch * ny;
        k = 0;
        for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                px = (x + dx * cw) % bx;
                if (px < 0) px += bx;
                py = (y + dy * ch) % by;
                if (py < 0) py += by;
                r.cell_index = IDX_W'((px / cw) * ny + py / ch);
                r.slot = SLOT_W'((dx + 1) * 3 + dy + 1);
                r.last = (k == 8);
                expected_cells.insert(expected_cells.size(), r);
                k++;
            end
        end
    endtask

    // Driver: offer queued positions, hold payload until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_cells(s_pos_x, s_pos_y);
                positions_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_pos_x <= pending_pos[0].pos_x;
                    s_pos_y <= pending_pos[0].pos_y;
                    void'(pending_pos.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        cell_res_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_cells.size() == 0) begin
                    $error("unexpected result index=%0d slot=%0d", m_cell_index, m_neighbor_slot);
                    errors++;
                end else begin
                    e = expected_cells.pop_front();
                    if (m_cell_index !== e.cell_index) begin
                        $error("cell_index expected %0d actual %0d", e.cell_index, m_cell_index);
                        errors++;
                    end
                    if (m_neighbor_slot !== e.slot) begin
                        $error("neighbor_slot expected %0d actual %0d", e.slot, m_neighbor_slot);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, m_last);
                        errors++;
                    end
                end
            end
            // Hold off the receiver for a fixed stretch when asked.
            if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
            else if (hold_req)
                hold_cnt <= 300;
            m_ready <= (hold_cnt == 0) && !hold_req &&
                       ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles without any accepted request or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("periodic_neighbor_cell_indices: mismatch");
            $finish;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CELL_WIDTH:   cfg_width = val[7:0];
            REG_CELL_HEIGHT:  cfg_height = val[7:0];
            REG_CELLS_ACROSS: cfg_across = val[8:0];
            REG_CELLS_DOWN:   cfg_down = val[8:0];
        endcase
    endtask

    task automatic configure(input int w, input int h, input int a, input int d);
        apb_write(REG_CELL_WIDTH, w);
        apb_write(REG_CELL_HEIGHT, h);
        apb_write(REG_CELLS_ACROSS, a);
        apb_write(REG_CELLS_DOWN, d);
    endtask

    task automatic push_pos(input logic [15:0] x, input logic [15:0] y);
        pos_req_t p;
        p.pos_x = x;
        p.pos_y = y;
        pending_pos.insert(pending_pos.size(), p);
    endtask

    // Wait until every queued request is accepted and every result is back.
    task automatic drain;
        while (pending_pos.size() > 0 || s_valid || expected_cells.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                push_pos(16'($urandom), 16'($urandom));
            else
                push_pos(16'($urandom_range(3000)), 16'($urandom_range(3000) - 500));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings: extremes, signs, cell borders.
        push_pos(16'h0000, 16'h0000);
        push_pos(16'h7FFF, 16'h7FFF);
        push_pos(16'h8000, 16'h8000);
        push_pos(16'hFFFF, 16'h0001);
        push_pos(16'd999, 16'd990);
        push_pos(16'd9, 16'd10);
        push_pos(16'h5555, 16'hAAAA);
        push_pos(16'hAAAA, 16'h5555);
        drain();

        // Zero sizes and counts act as one.
        configure(0, 0, 0, 0);
        push_pos(16'd5, 16'hFFF0);
        push_pos(16'h7FFF, 16'h8000);
        drain();

        // Oversized counts saturate; largest index reachable.
        configure(255, 255, 511, 300);
        push_pos(16'h0000, 16'h0000);
        push_pos(16'hFFFF, 16'hFFFF);
        push_pos(16'h7FFF, 16'h8000);
        push_pos(16'd200, 16'(65025 - 65536));
        drain();

        configure(1, 1, 256, 256);
        push_pos(16'd255, 16'd255);
        push_pos(16'h8000, 16'h7FFF);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        configure(7, 13, 37, 19);
        send_idle_pct = 0;
        hold_req = 1'b1;
        wait (hold_cnt != 0);
        hold_req = 1'b0;
        random_batch(40);
        wait (hold_cnt == 0);
        send_idle_pct = 28;
        drain();

        // Stretch with no idling on either side.
        configure(3, 250, 2, 256);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_batch(30);
        drain();
        send_idle_pct = 28;
        recv_idle_pct = 28;

        for (int ph = 0; ph < 3; ph++) begin
            configure($urandom_range(255), $urandom_range(255),
                      $urandom_range(511), $urandom_range(511));
            random_batch(12);
            drain();
        end

        $display("covered %0d positions, %0d neighbor indices, reset/zero/max/random grids",
                 positions_sent, results_seen);
        if (errors == 0)
            $display("periodic_neighbor_cell_indices: match");
        else
            $display("periodic_neighbor_cell_indices: mismatch");
        $finish;
    end
endmodule
